// File: hw/rtl/tsdm_pkg.sv
// package: shared types, codes and calibration constants of the touch sample mapper
`default_nettype none

package tsdm_pkg;

  // result classification codes
  typedef enum logic [2:0] {
    EvUncertain = 3'd0,
    EvNoTouch   = 3'd1,
    EvPresent   = 3'd2,
    EvTouch     = 3'd3,
    EvRelease   = 3'd4
  } event_e;

  // rotation codes
  localparam logic [1:0] RotNone     = 2'd0;
  localparam logic [1:0] RotQuarter  = 2'd1;
  localparam logic [1:0] RotHalf     = 2'd2;
  localparam logic [1:0] RotThreeQtr = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgRotation   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTouchThr   = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgReleaseThr = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgDebounce   = 8'd3;

  // configuration reset values
  localparam logic [1:0]  RotationRst   = RotNone;
  localparam logic [11:0] TouchThrRst   = 12'd5;
  localparam logic [11:0] ReleaseThrRst = 12'd0;
  localparam logic [15:0] DebounceRst   = 16'd20;

  // calibration limits
  localparam logic [11:0] LongLo  = 12'd300;
  localparam logic [11:0] ShortLo = 12'd550;
  localparam logic [9:0]  LongSpan  = 10'd320;
  localparam logic [9:0]  ShortSpan = 10'd240;

  // span / (hi - lo) folded with a 2^-26 reciprocal: 24/305 and 32/345,
  // rounded up so the truncated quotient is exact over all 12-bit offsets
  localparam int unsigned RecipShift = 26;
  localparam int unsigned MulW = 23;
  localparam logic [MulW-1:0] ShortMul = 23'd5280720;
  localparam logic [MulW-1:0] LongMul  = 23'd6224608;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 64;

  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] now_ms;
    logic [11:0] pressure;
    logic [11:0] raw_y;
    logic [11:0] raw_x;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        pad;
    event_e            event_res;
    logic [11:0]       raw_y_out;
    logic [11:0]       raw_x_out;
    logic [11:0]       pressure_out;
    logic signed [9:0] screen_y;
    logic signed [9:0] screen_x;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/tsdm_map.sv
// one axis of the coordinate mapping: offset, scaled quotient, mirror
`default_nettype none

module tsdm_map
  import tsdm_pkg::*;
(
  input  wire logic [11:0]       raw_i,
  input  wire logic              long_axis_i,
  input  wire logic              mirror_i,
  output logic signed [9:0]      screen_o
);

  logic [11:0]        lo;
  logic [MulW-1:0]    mul;
  logic [9:0]         span;
  logic               below;
  logic [11:0]        offset;
  logic [12+MulW-1:0] product;
  logic [8:0]         quot;
  logic [9:0]         base;

  always_comb begin
    lo     = long_axis_i ? LongLo : ShortLo;
    mul    = long_axis_i ? LongMul : ShortMul;
    span   = long_axis_i ? LongSpan : ShortSpan;
    below  = raw_i < lo;
    offset = below ? (lo - raw_i) : (raw_i - lo);
    // quotient magnitude; sign applied after so division truncates toward zero
    product = {{MulW{1'b0}}, offset} * {12'd0, mul};
    quot    = product[RecipShift+8:RecipShift];
    base    = mirror_i ? span : 10'd0;
    if (below ^ mirror_i) begin
      screen_o = $signed(base - {1'b0, quot});
    end else begin
      screen_o = $signed(base + {1'b0, quot});
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/touch_sample_debounce_map.sv
// top level: touch sample mapper with touch/release hysteresis and debounce
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | raw sample, 72-bit tdata
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | mapped result, 64-bit tdata
//  cfg      | in        | cfg_valid_i/cfg_ready_o     | register index and write data
//
// one sample per cycle unless the result side stalls; input register, then result register
// the touch/debounce state is updated as a sample moves into the result register,
// so consecutive samples chain through it without bubbles
// reset clears configuration to defaults, touch state to released, start time to 0
// a stalled result holds in the result register while one more sample waits in
// the input register; cfg writes are always taken
`default_nettype none

module touch_sample_debounce_map
  import tsdm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // raw_x[11:0], raw_y[23:12], pressure[35:24], now_ms[67:36], zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // screen_x[9:0], screen_y[19:10], pressure_out[31:20], raw_x_out[43:32],
  // raw_y_out[55:44], event_res[58:56], zero pad
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [1:0]  rotation_q;
  logic [11:0] touch_thr_q;
  logic [11:0] release_thr_q;
  logic [15:0] debounce_q;

  logic        touched_q, touched_d;
  logic [31:0] start_q, start_d;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;
  logic      advance;

  logic              long_x, mirror;
  logic signed [9:0] screen_x, screen_y;
  logic              cand;
  event_e            ev;
  logic [31:0]       elapsed;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q    <= RotationRst;
      touch_thr_q   <= TouchThrRst;
      release_thr_q <= ReleaseThrRst;
      debounce_q    <= DebounceRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRotation:   rotation_q    <= cfg_data_i[1:0];
        CfgTouchThr:   touch_thr_q   <= cfg_data_i[11:0];
        CfgReleaseThr: release_thr_q <= cfg_data_i[11:0];
        CfgDebounce:   debounce_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: input stage drains whenever the result register is free or taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      touched_q   <= 1'b0;
      start_q     <= 32'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        touched_q   <= touched_d;
        start_q     <= start_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= s_axis_tdata;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  // rotation picks which raw axis uses the long limits and whether the axes mirror
  always_comb begin
    case (rotation_q)
      RotQuarter:  begin long_x = 1'b1; mirror = 1'b1; end
      RotHalf:     begin long_x = 1'b0; mirror = 1'b1; end
      RotThreeQtr: begin long_x = 1'b1; mirror = 1'b0; end
      default:     begin long_x = 1'b0; mirror = 1'b0; end
    endcase
  end

  tsdm_map u_map_x (
    .raw_i       (in_item_q.raw_x),
    .long_axis_i (long_x),
    .mirror_i    (mirror),
    .screen_o    (screen_x)
  );

  tsdm_map u_map_y (
    .raw_i       (in_item_q.raw_y),
    .long_axis_i (!long_x),
    .mirror_i    (mirror),
    .screen_o    (screen_y)
  );

  // hysteresis and debounce
  always_comb begin
    cand      = touched_q;
    ev        = EvUncertain;
    touched_d = touched_q;
    start_d   = start_q;
    elapsed   = in_item_q.now_ms - start_q;
    if (in_item_q.pressure >= touch_thr_q) begin
      cand = 1'b1;
      ev   = EvPresent;
    end else if (in_item_q.pressure <= release_thr_q) begin
      cand = 1'b0;
      ev   = EvNoTouch;
    end
    if (cand == touched_q) begin
      start_d = in_item_q.now_ms;
    end else if (elapsed >= {16'd0, debounce_q}) begin
      start_d   = in_item_q.now_ms;
      touched_d = cand;
      ev        = cand ? EvTouch : EvRelease;
    end
  end

  always_comb begin
    out_item_d              = '0;
    out_item_d.screen_x     = screen_x;
    out_item_d.screen_y     = screen_y;
    out_item_d.pressure_out = in_item_q.pressure;
    out_item_d.raw_x_out    = in_item_q.raw_x;
    out_item_d.raw_y_out    = in_item_q.raw_y;
    out_item_d.event_res    = ev;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tsdm_checker.sv
// checker on the top-level ports of the touch sample mapper, with its bind
`default_nettype none

module tsdm_checker
  import tsdm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  out_item_t beat;
  logic      seen_touched_q;

  assign beat = m_axis_tdata;

  // touch state as seen from the delivered events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_touched_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (beat.event_res == EvTouch) begin
        seen_touched_q <= 1'b1;
      end else if (beat.event_res == EvRelease) begin
        seen_touched_q <= 1'b0;
      end
    end
  end

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_no_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted sample did not reach the output in two cycles");

  a_touch_alternates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && beat.event_res == EvTouch |-> !seen_touched_q)
    else $error("touch event while already touched");

  a_release_alternates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && beat.event_res == EvRelease |-> seen_touched_q)
    else $error("release event while already released");

endmodule

bind touch_sample_debounce_map tsdm_checker u_tsdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
